FILE: design/slt_pkg.sv
// shared types and constants for the segment lookaside table
// no dependencies
`default_nettype none

package slt_pkg;

    localparam int SEG_W       = 36;
    localparam int VSID_W      = 52;
    localparam int SLOT_W      = 6;
    localparam int CMD_SLOT_W  = 8;
    localparam int CFG_DATA_W  = 6;
    localparam int ENTRIES_DEF = 64;

    typedef enum logic
    {
        OP_TRANSLATE = 1'b0,
        OP_ALLOCATE  = 1'b1
    } slt_op_t;

    typedef enum logic
    {
        CFG_KERNEL_MODE   = 1'b0,
        CFG_RESERVED_SLOT = 1'b1
    } slt_cfg_idx_t;

    typedef enum logic [1:0]
    {
        CMD_HIT    = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_FULL   = 2'd2
    } slt_cmd_kind_t;

    typedef struct packed
    {
        slt_op_t             opcode;
        logic [SEG_W-1:0]    segment_id;
        logic [VSID_W-1:0]   new_vsid;
        logic                large_page;
        logic [SLOT_W-1:0]   start_slot;
    } slt_item_t;

    typedef struct packed
    {
        logic [VSID_W-1:0]   vsid;
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic                large_flag;
        logic                table_full;
    } slt_result_t;

    typedef struct packed
    {
        slt_cfg_idx_t          index;
        logic [CFG_DATA_W-1:0] data;
    } slt_cfg_wr_t;

    // classified work handed from front to back
    typedef struct packed
    {
        slt_cmd_kind_t         kind;
        logic [CMD_SLOT_W-1:0] slot;
        logic [VSID_W-1:0]     vsid;
        logic                  large_page;
    } slt_cmd_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } slt_q_status_t;

endpackage

`default_nettype wire

FILE: design/slt_front.sv
// front end: takes items, holds the tag array and valid bits, classifies each item
// depends on slt_pkg
`default_nettype none

module slt_front #(
    parameter int ENTRIES = slt_pkg::ENTRIES_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_en,
    input  slt_pkg::slt_cfg_wr_t  cfg,
    input  wire                   item_valid,
    output logic                  item_stall,
    input  slt_pkg::slt_item_t    item,
    input  slt_pkg::slt_q_status_t q_status,
    output logic                  push,
    output slt_pkg::slt_cmd_t     cmd
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CSW   = slt_pkg::CMD_SLOT_W;
    localparam int SW    = slt_pkg::SLOT_W;

    logic                       busy_reg;
    logic                       busy_next;
    slt_pkg::slt_item_t         in_reg;
    logic                       kernel_reg;
    logic [SW-1:0]              reserved_reg;
    logic [ENTRIES-1:0]         valid_reg;
    logic [slt_pkg::SEG_W-1:0]  tag_reg [ENTRIES];

    logic [ENTRIES-1:0]         match;
    logic [ENTRIES-1:0]         free;
    logic [ENTRIES-1:0]         upper;
    logic [IDX_W-1:0]           start_idx;
    logic [IDX_W-1:0]           pick;
    logic [IDX_W-1:0]           match_idx;
    logic                       accept;
    logic                       do_write;
    logic [IDX_W-1:0]           write_idx;

    function automatic logic [IDX_W-1:0] lowest_set(input logic [ENTRIES-1:0] v);
        logic [ENTRIES-1:0] onehot;
        logic [IDX_W-1:0]   idx;
        onehot = v & (~v + ENTRIES'(1));
        idx    = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            for (int b = 0; b < IDX_W; b++)
            begin
                if (i[b])
                begin
                    idx[b] = idx[b] | onehot[i];
                end
            end
        end
        return idx;
    endfunction

    assign item_stall = busy_reg && q_status.full;
    assign accept     = item_valid && !item_stall;
    assign push       = busy_reg && !q_status.full;

    always_comb
    begin
        start_idx = IDX_W'(32'(in_reg.start_slot) % ENTRIES);
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (tag_reg[i] == in_reg.segment_id);
            free[i]  = !valid_reg[i] && !(kernel_reg && (int'(reserved_reg) == i));
            upper[i] = (i >= int'(start_idx));
        end
        match_idx = lowest_set(match);
        // wrapped scan: slots at or above the start first, then from zero
        if (|(free & upper))
        begin
            pick = lowest_set(free & upper);
        end
        else
        begin
            pick = lowest_set(free);
        end

        cmd.vsid       = in_reg.new_vsid;
        cmd.large_page = in_reg.large_page;
        priority if (in_reg.opcode == slt_pkg::OP_TRANSLATE && |match)
        begin
            cmd.kind = slt_pkg::CMD_HIT;
            cmd.slot = CSW'(match_idx);
        end
        else if (|free)
        begin
            cmd.kind = slt_pkg::CMD_INSERT;
            cmd.slot = CSW'(pick);
        end
        else if (!kernel_reg)
        begin
            // every slot is valid, so the first one scanned is the victim
            cmd.kind = slt_pkg::CMD_INSERT;
            cmd.slot = CSW'(start_idx);
        end
        else
        begin
            cmd.kind = slt_pkg::CMD_FULL;
            cmd.slot = '0;
        end

        do_write  = push && (cmd.kind == slt_pkg::CMD_INSERT);
        write_idx = IDX_W'(cmd.slot);

        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (push)
        begin
            busy_next = 1'b0;
        end
        else
        begin
            busy_next = busy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            kernel_reg   <= 1'b0;
            reserved_reg <= '0;
            valid_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (cfg_en)
            begin
                unique case (cfg.index)
                    slt_pkg::CFG_KERNEL_MODE:   kernel_reg   <= cfg.data[0];
                    slt_pkg::CFG_RESERVED_SLOT: reserved_reg <= cfg.data[SW-1:0];
                endcase
            end
            if (do_write)
            begin
                valid_reg[write_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= item;
        end
        if (do_write)
        begin
            tag_reg[write_idx] <= in_reg.segment_id;
        end
    end

endmodule

`default_nettype wire

FILE: design/slt_queue.sv
// two-entry queue of classified commands between front and back
// depends on slt_pkg
`default_nettype none

module slt_queue (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push,
    input  slt_pkg::slt_cmd_t      push_cmd,
    input  wire                    pop,
    output slt_pkg::slt_cmd_t      pop_cmd,
    output slt_pkg::slt_q_status_t status
);

    slt_pkg::slt_cmd_t store_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    assign pop_cmd      = store_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: design/slt_back.sv
// back end: vsid and large-page memory, result register
// depends on slt_pkg
`default_nettype none

module slt_back #(
    parameter int ENTRIES = slt_pkg::ENTRIES_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  slt_pkg::slt_q_status_t q_status,
    input  slt_pkg::slt_cmd_t      cmd,
    output logic                   pop,
    output logic                   result_valid,
    input  wire                    result_stall,
    output slt_pkg::slt_result_t   result
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int VW    = slt_pkg::VSID_W;
    localparam int SW    = slt_pkg::SLOT_W;

    logic [VW:0]        mem [ENTRIES];
    logic [VW:0]        rd_reg;
    slt_pkg::slt_cmd_t  meta_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [IDX_W-1:0]   addr;

    assign addr         = IDX_W'(cmd.slot);
    assign pop          = !q_status.empty && (!out_valid_reg || !result_stall);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end

        result.slot = SW'(meta_reg.slot);
        unique case (meta_reg.kind)
            slt_pkg::CMD_HIT:
            begin
                result.vsid       = rd_reg[VW-1:0];
                result.hit        = 1'b1;
                result.large_flag = rd_reg[VW];
                result.table_full = 1'b0;
            end
            slt_pkg::CMD_INSERT:
            begin
                result.vsid       = meta_reg.vsid;
                result.hit        = 1'b0;
                result.large_flag = meta_reg.large_page;
                result.table_full = 1'b0;
            end
            slt_pkg::CMD_FULL:
            begin
                result.vsid       = '0;
                result.hit        = 1'b0;
                result.slot       = '0;
                result.large_flag = 1'b0;
                result.table_full = 1'b1;
            end
            default:
            begin
                result.vsid       = '0;
                result.hit        = 1'b0;
                result.slot       = '0;
                result.large_flag = 1'b0;
                result.table_full = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // commands leave the queue in order, so a write always lands before a later read
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            meta_reg <= cmd;
            if (cmd.kind == slt_pkg::CMD_INSERT)
            begin
                mem[addr] <= {cmd.large_page, cmd.vsid};
            end
            if (cmd.kind == slt_pkg::CMD_HIT)
            begin
                rd_reg <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/segment_lookaside_table.sv
// top level of the segment lookaside table
// depends on slt_pkg, slt_front, slt_queue, slt_back
`default_nettype none

// Maps an effective segment id to a vsid. A translate transaction searches the valid
// slots (lowest matching slot wins) and returns the stored vsid; on a miss, and always
// for an allocate transaction, the supplied vsid is inserted at the first empty slot
// scanned upward from start_slot with wrap, the reserved slot skipped in kernel mode.
// A full user table evicts the start slot; a full kernel table returns table_full and
// writes nothing. In the front, the tag compare and the wrapped priority pick update the
// valid bits and tags; in the back the single port of the vsid memory is written or read.
// A two-entry queue between them lets the block sustain one transaction per cycle while
// the queue is not full and result_stall is low; a transaction moves from the front's
// input register via the queue to the back's registers. No clearing pass follows reset.
// Configuration is accepted every cycle and must only be written while idle.

module segment_lookaside_table #(
    parameter int ENTRIES = slt_pkg::ENTRIES_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                item_valid,
    output logic                               item_stall,
    input  slt_pkg::slt_item_t                 item,
    output logic                               result_valid,
    input  wire                                result_stall,
    output slt_pkg::slt_result_t               result,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  slt_pkg::slt_cfg_idx_t              cfg_index,
    input  wire [slt_pkg::CFG_DATA_W-1:0]      cfg_data
);

    slt_pkg::slt_cfg_wr_t   cfg;
    slt_pkg::slt_q_status_t q_status;
    slt_pkg::slt_cmd_t      push_cmd;
    slt_pkg::slt_cmd_t      pop_cmd;
    logic                   q_push;
    logic                   q_pop;

    assign cfg_ready = 1'b1;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    slt_front #(
        .ENTRIES (ENTRIES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_en     (cfg_valid && cfg_ready),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_status   (q_status),
        .push       (q_push),
        .cmd        (push_cmd)
    );

    slt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    slt_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .cmd          (pop_cmd),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("command queue read while empty");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.table_full |->
            !result.hit && result.slot == '0 && result.vsid == '0)
        else $error("table_full result carries data");

    a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> result_valid)
        else $error("popped command produced no result");
`endif

endmodule

`default_nettype wire
